/* rtl/vng_pkg.sv */
// ----------------------------------------------------------------------------
// vng_pkg
// Shared widths, request codes and types of the vertex normal generator.
// ----------------------------------------------------------------------------
package vng_pkg;

  localparam int MAX_VERTICES_DEF = 1024;
  localparam int SUM_BITS_DEF     = 24;

  localparam int IDX_W  = 10;   // vertex index field
  localparam int POS_W  = 16;   // Q8.8 position component
  localparam int NRM_W  = 16;   // Q1.14 normal component
  localparam int CW     = 36;   // vector width into the normalizer
  localparam int ONE_Q14 = 16384;

  localparam logic [1:0] MODE_POS    = 2'd0;
  localparam logic [1:0] MODE_TRI    = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef logic [2:0][CW-1:0] vec_t;

  typedef struct packed {
    logic                   done;
    logic                   zero;
    logic [2:0][NRM_W-1:0]  n;
  } norm_res_t;

endpackage

/* rtl/vng_if.sv */
// ----------------------------------------------------------------------------
// vng_if
// Request and result channels of the vertex normal generator.
// ----------------------------------------------------------------------------
interface vng_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       mode;
  logic [vng_pkg::IDX_W-1:0]        vertex_index;
  logic signed [vng_pkg::POS_W-1:0] pos_x;
  logic signed [vng_pkg::POS_W-1:0] pos_y;
  logic signed [vng_pkg::POS_W-1:0] pos_z;
  logic [vng_pkg::IDX_W-1:0]        corner_a;
  logic [vng_pkg::IDX_W-1:0]        corner_b;
  logic [vng_pkg::IDX_W-1:0]        corner_c;

  modport source (output valid, mode, vertex_index, pos_x, pos_y, pos_z,
                  corner_a, corner_b, corner_c, input ready);
  modport sink   (input valid, mode, vertex_index, pos_x, pos_y, pos_z,
                  corner_a, corner_b, corner_c, output ready);
endinterface

interface vng_out_if;
  logic                             valid;
  logic                             ready;
  logic [vng_pkg::IDX_W-1:0]        out_vertex;
  logic signed [vng_pkg::NRM_W-1:0] normal_x;
  logic signed [vng_pkg::NRM_W-1:0] normal_y;
  logic signed [vng_pkg::NRM_W-1:0] normal_z;
  logic                             degenerate;

  modport source (output valid, out_vertex, normal_x, normal_y, normal_z,
                  degenerate, input ready);
  modport sink   (input valid, out_vertex, normal_x, normal_y, normal_z,
                  degenerate, output ready);
endinterface

/* rtl/vng_norm.sv */
// ----------------------------------------------------------------------------
// vng_norm
// Iterative vector normalizer: shift to range, sum of squares, bit-serial
// square root and three bit-serial divisions giving a Q1.14 unit vector.
// ----------------------------------------------------------------------------
module vng_norm (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  vng_pkg::vec_t     vec,
  output vng_pkg::norm_res_t res
);

  localparam int CW = vng_pkg::CW;

  typedef enum logic [7:0] {
    N_IDLE  = 8'b0000_0001,
    N_SHIFT = 8'b0000_0010,
    N_SQ    = 8'b0000_0100,
    N_SQRT  = 8'b0000_1000,
    N_DLOAD = 8'b0001_0000,
    N_DIV   = 8'b0010_0000,
    N_STORE = 8'b0100_0000,
    N_DONE  = 8'b1000_0000
  } nst_t;

  nst_t                          st_r;
  logic [CW-1:0]                 m_r [3];
  logic [2:0]                    neg_r;
  logic [59:0]                   prod_r;
  logic [63:0]                   acc_r;
  logic [63:0]                   v_r;
  logic [63:0]                   root_r;
  logic [63:0]                   bit_r;
  logic [46:0]                   num_r;
  logic [46:0]                   den_r;
  logic [15:0]                   q_r;
  logic [4:0]                    cnt_r;
  logic [1:0]                    comp_r;
  logic [2:0][vng_pkg::NRM_W-1:0] n_r;
  logic                          zero_r;
  logic                          done_r;

  logic [CW-1:0] mag [3];
  logic [CW-1:0] mx;
  logic [63:0]   trial;
  logic [15:0]   qc;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = vec[i][CW-1] ? (~vec[i] + CW'(1)) : vec[i];
    end
    mx = m_r[0];
    if (m_r[1] > mx) mx = m_r[1];
    if (m_r[2] > mx) mx = m_r[2];
    trial = root_r + bit_r;
    qc = (q_r > 16'(vng_pkg::ONE_Q14)) ? 16'(vng_pkg::ONE_Q14) : q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= N_IDLE;
      done_r <= 1'b0;
    end else begin
      unique case (st_r)
        N_IDLE: begin
          done_r <= 1'b0;
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              m_r[i]   <= mag[i];
              neg_r[i] <= vec[i][CW-1];
            end
            if (vec == '0) begin
              n_r    <= '0;
              zero_r <= 1'b1;
              st_r   <= N_DONE;
            end else begin
              zero_r <= 1'b0;
              st_r   <= N_SHIFT;
            end
          end
        end
        N_SHIFT: begin
          // Bring the largest magnitude into [2^29, 2^30).
          if (mx[CW-1:29] == '0) begin
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] << 1;
          end else if (mx[CW-1:30] != '0) begin
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] >> 1;
          end else begin
            cnt_r <= '0;
            acc_r <= '0;
            st_r  <= N_SQ;
          end
        end
        N_SQ: begin
          if (cnt_r[1:0] != 2'd3) begin
            prod_r <= m_r[cnt_r[1:0]][29:0] * m_r[cnt_r[1:0]][29:0];
          end
          if (cnt_r[1:0] != 2'd0) acc_r <= acc_r + 64'(prod_r);
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r[1:0] == 2'd3) begin
            v_r    <= acc_r + 64'(prod_r);
            root_r <= '0;
            bit_r  <= 64'h4000_0000_0000_0000;
            st_r   <= N_SQRT;
          end
        end
        N_SQRT: begin
          if (v_r >= trial) begin
            v_r    <= v_r - trial;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            comp_r <= '0;
            st_r   <= N_DLOAD;
          end
        end
        N_DLOAD: begin
          // Numerator carries the rounding term of half the length.
          num_r <= 47'({m_r[comp_r][29:0], 14'b0}) + 47'(root_r[31:1]);
          den_r <= 47'(root_r[31:0]) << 15;
          q_r   <= '0;
          cnt_r <= 5'd15;
          st_r  <= N_DIV;
        end
        N_DIV: begin
          if (num_r >= den_r) begin
            num_r          <= num_r - den_r;
            q_r[cnt_r[3:0]] <= 1'b1;
          end
          den_r <= den_r >> 1;
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) st_r <= N_STORE;
        end
        N_STORE: begin
          n_r[comp_r] <= neg_r[comp_r] ? (~qc + 16'd1) : qc;
          if (comp_r == 2'd2) begin
            st_r <= N_DONE;
          end else begin
            comp_r <= comp_r + 2'd1;
            st_r   <= N_DLOAD;
          end
        end
        N_DONE: begin
          done_r <= 1'b1;
          st_r   <= N_IDLE;
        end
        default: st_r <= N_IDLE;
      endcase
    end
  end

  assign res.done = done_r;
  assign res.zero = zero_r;
  assign res.n    = n_r;

endmodule

/* rtl/vertex_normal_generator.sv */
// ----------------------------------------------------------------------------
// vertex_normal_generator
// Smooth per-vertex normals by summing unit face normals into each corner.
// ----------------------------------------------------------------------------
// Usage: requests arrive on in_ch (valid/ready). Mode 0 stores a Q8.8
// position, mode 1 adds the unit normal of a triangle into the sums of its
// three corners, mode 2 reads one vertex, returns its Q1.14 unit normal on
// out_ch and clears its sum. Requests with an index at or above
// MAX_VERTICES, and mode 3, are dropped without a result.
// Requests are processed one at a time. In a triangle or a read the
// normalizer's range shift, 32-step square root and three 16-step
// divisions dominate (they are skipped for a zero cross product or a zero
// sum), plus single-port memory reads and the read-modify-write of the
// three corner sums.
// After reset the sum memory is cleared, one entry a cycle, with in_ch.ready
// low. The result sits in an output register; a stalled receiver holds it
// while the next request is taken, and a read only waits at its end if the
// previous result is still there.
// ----------------------------------------------------------------------------
module vertex_normal_generator #(
  parameter int MAX_VERTICES = vng_pkg::MAX_VERTICES_DEF,
  parameter int SUM_BITS     = vng_pkg::SUM_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  vng_in_if.sink    in_ch,
  vng_out_if.source out_ch
);

  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int CW    = vng_pkg::CW;
  localparam int PW    = 3 * vng_pkg::POS_W;
  localparam int SW    = 3 * SUM_BITS;
  localparam int POS_W = vng_pkg::POS_W;

  typedef enum logic [14:0] {
    T_CLEAR = 15'b000_0000_0000_0001,
    T_IDLE  = 15'b000_0000_0000_0010,
    T_PWR   = 15'b000_0000_0000_0100,
    T_RDA   = 15'b000_0000_0000_1000,
    T_RDB   = 15'b000_0000_0001_0000,
    T_RDC   = 15'b000_0000_0010_0000,
    T_RDW   = 15'b000_0000_0100_0000,
    T_CROSS = 15'b000_0000_1000_0000,
    T_NORM  = 15'b000_0001_0000_0000,
    T_SRD   = 15'b000_0010_0000_0000,
    T_SWR   = 15'b000_0100_0000_0000,
    T_VRD   = 15'b000_1000_0000_0000,
    T_VCLR  = 15'b001_0000_0000_0000,
    T_VNORM = 15'b010_0000_0000_0000,
    T_OUT   = 15'b100_0000_0000_0000
  } tst_t;

  tst_t                          state_r;
  logic [AW-1:0]                 clr_cnt_r;
  logic [AW-1:0]                 vi_r;
  logic [PW-1:0]                 pos_r;
  logic [AW-1:0]                 corner_r [3];
  logic [1:0]                    k_r;
  logic [PW-1:0]                 pa_r;
  logic [PW-1:0]                 pb_r;
  logic signed [POS_W:0]         d_r [3];
  logic signed [POS_W:0]         e_r [3];
  logic [2:0]                    step_r;
  logic signed [2*POS_W+1:0]     prod_r;
  logic signed [2*POS_W+1:0]     tmp_r;
  vng_pkg::vec_t                 cvec_r;
  logic                          norm_start_r;
  logic [2:0][vng_pkg::NRM_W-1:0] fn_r;
  logic                          degen_r;
  vng_pkg::norm_res_t            norm_res;

  logic                          out_valid_r;
  logic [vng_pkg::IDX_W-1:0]     out_vertex_r;
  logic signed [vng_pkg::NRM_W-1:0] out_nx_r;
  logic signed [vng_pkg::NRM_W-1:0] out_ny_r;
  logic signed [vng_pkg::NRM_W-1:0] out_nz_r;
  logic                          out_degen_r;

  logic [PW-1:0] pos_mem [MAX_VERTICES];
  logic [PW-1:0] pos_rdata_r;
  logic [AW-1:0] pos_addr;
  logic          pos_we;
  logic [SW-1:0] sum_mem [MAX_VERTICES];
  logic [SW-1:0] sum_rdata_r;
  logic [AW-1:0] sum_addr;
  logic          sum_we;
  logic [SW-1:0] sum_wdata;

  logic                      accept;
  logic                      vi_ok, a_ok, b_ok, c_ok;
  logic signed [POS_W:0]     op_a, op_b;
  logic signed [2*POS_W+2:0] cdiff;
  logic                      out_free;

  function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] a,
                                                  input logic [vng_pkg::NRM_W-1:0] b);
    logic signed [SUM_BITS:0] s;
    s = $signed({a[SUM_BITS-1], a}) + (SUM_BITS+1)'($signed(b));
    if (s[SUM_BITS] != s[SUM_BITS-1]) begin
      return s[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
    end
    return s[SUM_BITS-1:0];
  endfunction

  function automatic logic signed [POS_W-1:0] pcomp(input logic [PW-1:0] w,
                                                    input int i);
    return $signed(w[PW-1-i*POS_W -: POS_W]);
  endfunction

  function automatic logic [CW-1:0] sum_ext(input logic [SUM_BITS-1:0] s);
    return {{(CW-SUM_BITS){s[SUM_BITS-1]}}, s};
  endfunction

  assign accept   = in_ch.valid && in_ch.ready;
  assign vi_ok    = 32'(in_ch.vertex_index) < 32'(MAX_VERTICES);
  assign a_ok     = 32'(in_ch.corner_a) < 32'(MAX_VERTICES);
  assign b_ok     = 32'(in_ch.corner_b) < 32'(MAX_VERTICES);
  assign c_ok     = 32'(in_ch.corner_c) < 32'(MAX_VERTICES);
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == T_IDLE);

  // Cross product terms, one product per cycle.
  always_comb begin
    case (step_r)
      3'd0:    begin op_a = d_r[1]; op_b = e_r[2]; end
      3'd1:    begin op_a = d_r[2]; op_b = e_r[1]; end
      3'd2:    begin op_a = d_r[2]; op_b = e_r[0]; end
      3'd3:    begin op_a = d_r[0]; op_b = e_r[2]; end
      3'd4:    begin op_a = d_r[0]; op_b = e_r[1]; end
      default: begin op_a = d_r[1]; op_b = e_r[0]; end
    endcase
    cdiff = (2*POS_W+3)'(tmp_r) - (2*POS_W+3)'(prod_r);
  end

  always_comb begin
    unique case (state_r)
      T_PWR:   pos_addr = vi_r;
      T_RDA:   pos_addr = corner_r[0];
      T_RDB:   pos_addr = corner_r[1];
      default: pos_addr = corner_r[2];
    endcase
    pos_we = (state_r == T_PWR);

    unique case (state_r)
      T_CLEAR:        sum_addr = clr_cnt_r;
      T_SRD, T_SWR:   sum_addr = corner_r[k_r];
      default:        sum_addr = vi_r;
    endcase
    sum_we    = (state_r == T_CLEAR) || (state_r == T_SWR) || (state_r == T_VCLR);
    sum_wdata = '0;
    if (state_r == T_SWR) begin
      sum_wdata = {sat_add(sum_rdata_r[SW-1 -: SUM_BITS], fn_r[0]),
                   sat_add(sum_rdata_r[SW-1-SUM_BITS -: SUM_BITS], fn_r[1]),
                   sat_add(sum_rdata_r[SUM_BITS-1:0], fn_r[2])};
    end
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_addr] <= pos_r;
    pos_rdata_r <= pos_mem[pos_addr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_addr] <= sum_wdata;
    sum_rdata_r <= sum_mem[sum_addr];
  end

  vng_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (norm_start_r),
    .vec   (cvec_r),
    .res   (norm_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= T_CLEAR;
      clr_cnt_r    <= '0;
      norm_start_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      norm_start_r <= ((state_r == T_CROSS) && (step_r == 3'd6)) || (state_r == T_VCLR);
      if ((state_r == T_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        T_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
          if (32'(clr_cnt_r) == MAX_VERTICES - 1) state_r <= T_IDLE;
        end
        T_IDLE: begin
          if (accept) begin
            vi_r        <= AW'(in_ch.vertex_index);
            pos_r       <= {in_ch.pos_x, in_ch.pos_y, in_ch.pos_z};
            corner_r[0] <= AW'(in_ch.corner_a);
            corner_r[1] <= AW'(in_ch.corner_b);
            corner_r[2] <= AW'(in_ch.corner_c);
            unique case (in_ch.mode)
              vng_pkg::MODE_POS:  if (vi_ok) state_r <= T_PWR;
              vng_pkg::MODE_TRI:  if (a_ok && b_ok && c_ok) state_r <= T_RDA;
              vng_pkg::MODE_READ: if (vi_ok) state_r <= T_VRD;
              default:            state_r <= T_IDLE;
            endcase
          end
        end
        T_PWR:  state_r <= T_IDLE;
        T_RDA:  state_r <= T_RDB;
        T_RDB: begin
          pa_r    <= pos_rdata_r;
          state_r <= T_RDC;
        end
        T_RDC: begin
          pb_r    <= pos_rdata_r;
          state_r <= T_RDW;
        end
        T_RDW: begin
          for (int i = 0; i < 3; i++) begin
            d_r[i] <= (POS_W+1)'(pcomp(pb_r, i)) - (POS_W+1)'(pcomp(pa_r, i));
            e_r[i] <= (POS_W+1)'(pcomp(pos_rdata_r, i)) - (POS_W+1)'(pcomp(pa_r, i));
          end
          step_r  <= '0;
          state_r <= T_CROSS;
        end
        T_CROSS: begin
          if (step_r != 3'd6) prod_r <= op_a * op_b;
          if (step_r != 3'd0) begin
            if (step_r[0]) begin
              tmp_r <= prod_r;
            end else begin
              cvec_r[step_r[2:1] - 2'd1] <= CW'(cdiff);
            end
          end
          step_r <= step_r + 3'd1;
          if (step_r == 3'd6) begin
            state_r <= T_NORM;
          end
        end
        T_NORM: begin
          if (norm_res.done) begin
            fn_r    <= norm_res.n;
            k_r     <= '0;
            state_r <= T_SRD;
          end
        end
        T_SRD: state_r <= T_SWR;
        T_SWR: begin
          // Each corner is written before the next is read, so repeated
          // corners see the updated sum.
          k_r <= k_r + 2'd1;
          state_r <= (k_r == 2'd2) ? T_IDLE : T_SRD;
        end
        T_VRD: state_r <= T_VCLR;
        T_VCLR: begin
          cvec_r[0]    <= sum_ext(sum_rdata_r[SW-1 -: SUM_BITS]);
          cvec_r[1]    <= sum_ext(sum_rdata_r[SW-1-SUM_BITS -: SUM_BITS]);
          cvec_r[2]    <= sum_ext(sum_rdata_r[SUM_BITS-1:0]);
          state_r      <= T_VNORM;
        end
        T_VNORM: begin
          if (norm_res.done) begin
            fn_r    <= norm_res.n;
            degen_r <= norm_res.zero;
            state_r <= T_OUT;
          end
        end
        T_OUT: begin
          if (out_free) begin
            out_vertex_r <= vng_pkg::IDX_W'(vi_r);
            out_nx_r     <= $signed(fn_r[0]);
            out_ny_r     <= $signed(fn_r[1]);
            out_nz_r     <= $signed(fn_r[2]);
            out_degen_r  <= degen_r;
            state_r      <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_vertex = out_vertex_r;
  assign out_ch.normal_x   = out_nx_r;
  assign out_ch.normal_y   = out_ny_r;
  assign out_ch.normal_z   = out_nz_r;
  assign out_ch.degenerate = out_degen_r;

  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    norm_res.done |-> (state_r == T_NORM || state_r == T_VNORM))
    else $error("normalizer finished while no request waited for it");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_degen_r) |-> (out_nx_r == 0 && out_ny_r == 0 && out_nz_r == 0))
    else $error("degenerate result carries a nonzero normal");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_nx_r >= -16384 && out_nx_r <= 16384 &&
                     out_ny_r >= -16384 && out_ny_r <= 16384 &&
                     out_nz_r >= -16384 && out_nz_r <= 16384))
    else $error("normal component outside the unit range");

  a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> out_valid_r)
    else $error("pending result dropped without a handshake");

endmodule
